>>> rtl/timed_pin_pulse_table_macros.svh
// Assertion macros for the pulse table top level.
`ifndef TIMED_PIN_PULSE_TABLE_MACROS_SVH
`define TIMED_PIN_PULSE_TABLE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TPPT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TPPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tppt_pkg.sv
// Shared types and constants for the pulse table.
package tppt_pkg;

   localparam int MAX_RESULTS = 4;
   localparam int CNT_BITS    = $clog2(MAX_RESULTS);

   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   localparam logic CMD_DRIVE  = 1'b0;
   localparam logic CMD_TOGGLE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic start;   // store a pulse and load its drive result
      logic latch;   // capture the tick time
      logic scan;    // capture the due vector
      logic emit;    // load one toggle result and free its slot
   } tppt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic due_any;
      logic emit_last;
   } tppt_stat_type;

endpackage

>>> rtl/tppt_req_if.sv
// Request channel: tick and start items.
interface tppt_req_if #(
   parameter int PIN_ID_BITS = 6
);
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [31:0]            now_ms;
   logic [PIN_ID_BITS-1:0] pin_id;
   logic [31:0]            duration_ms;
   logic                   end_level;

   modport source (output valid, action, now_ms, pin_id, duration_ms, end_level,
                   input ready);
   modport sink   (input valid, action, now_ms, pin_id, duration_ms, end_level,
                   output ready);
endinterface

>>> rtl/tppt_rsp_if.sv
// Response channel: pin drive and toggle commands.
interface tppt_rsp_if #(
   parameter int PIN_ID_BITS = 6
);
   logic                   valid;
   logic                   ready;
   logic [PIN_ID_BITS-1:0] out_pin;
   logic                   command;
   logic                   drive_level;
   logic                   slot_taken;
   logic                   last;

   modport source (output valid, out_pin, command, drive_level, slot_taken, last,
                   input ready);
   modport sink   (input valid, out_pin, command, drive_level, slot_taken, last,
                   output ready);
endinterface

>>> rtl/tppt_datapath.sv
// Slot table, deadline compare and result register of the pulse table.
module tppt_datapath #(
   parameter int SLOTS       = 4,
   parameter int PIN_ID_BITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tppt_pkg::tppt_cmd_type     cmd,
   output tppt_pkg::tppt_stat_type    stat,
   input  logic [31:0]                req_now_ms,
   input  logic [PIN_ID_BITS-1:0]     req_pin_id,
   input  logic [31:0]                req_duration_ms,
   input  logic                       req_end_level,
   output logic [PIN_ID_BITS-1:0]     rsp_out_pin,
   output logic                       rsp_command,
   output logic                       rsp_drive_level,
   output logic                       rsp_slot_taken,
   output logic                       rsp_last
);
   import tppt_pkg::*;

   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [SLOTS-1:0]       busy_ff, busy_in;
   logic [SLOTS-1:0]       due_ff, due_in;
   logic [31:0]            now_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [PIN_ID_BITS-1:0] slot_pin_ff [SLOTS];
   logic [31:0]            slot_deadline_ff [SLOTS];

   logic [PIN_ID_BITS-1:0] out_pin_ff;
   logic                   command_ff;
   logic                   drive_level_ff;
   logic                   slot_taken_ff;
   logic                   last_ff;

   logic [SLOT_BITS-1:0]   free_idx;
   logic                   free_any;
   logic [SLOT_BITS-1:0]   sel_idx;
   logic [SLOTS-1:0]       due_rest;
   logic                   emit_last;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) free_idx = SLOT_BITS'(i);
      end
   end
   assign free_any = ~&busy_ff;

   // lowest due slot still to be emitted
   always_comb begin
      sel_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (due_ff[i]) sel_idx = SLOT_BITS'(i);
      end
   end

   assign due_rest  = due_ff & ~(SLOTS'(1) << sel_idx);
   assign emit_last = (cnt_ff == CNT_BITS'(MAX_RESULTS - 1)) || (due_rest == '0);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         due_in[i] = busy_ff[i] && (now_ff >= slot_deadline_ff[i]);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (cmd.start && free_any) busy_in[free_idx] = 1'b1;
      if (cmd.emit)              busy_in[sel_idx]  = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && free_any) begin
         slot_pin_ff[free_idx]      <= req_pin_id;
         slot_deadline_ff[free_idx] <= req_now_ms + req_duration_ms;
      end
      if (cmd.latch) now_ff <= req_now_ms;
      if (cmd.scan) begin
         due_ff <= due_in;
         cnt_ff <= '0;
      end else if (cmd.emit) begin
         due_ff <= due_rest;
         cnt_ff <= cnt_ff + CNT_BITS'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         out_pin_ff     <= req_pin_id;
         command_ff     <= CMD_DRIVE;
         drive_level_ff <= ~req_end_level;
         slot_taken_ff  <= free_any;
         last_ff        <= 1'b1;
      end else if (cmd.emit) begin
         out_pin_ff     <= slot_pin_ff[sel_idx];
         command_ff     <= CMD_TOGGLE;
         drive_level_ff <= 1'b0;
         slot_taken_ff  <= 1'b0;
         last_ff        <= emit_last;
      end
   end

   assign stat.due_any   = |due_ff;
   assign stat.emit_last = emit_last;

   assign rsp_out_pin     = out_pin_ff;
   assign rsp_command     = command_ff;
   assign rsp_drive_level = drive_level_ff;
   assign rsp_slot_taken  = slot_taken_ff;
   assign rsp_last        = last_ff;

endmodule

>>> rtl/tppt_controller.sv
// Sequencing state machine of the pulse table.
module tppt_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output tppt_pkg::tppt_cmd_type  cmd,
   input  tppt_pkg::tppt_stat_type stat
);
   import tppt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_free;
   logic       req_xfer;

   assign out_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_action == ACTION_START) begin
                  cmd.start = 1'b1;
               end else begin
                  cmd.latch = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.due_any) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (cmd.start || cmd.emit)     out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> rtl/timed_pin_pulse_table.sv
// Top level of the timed pin pulse table.
//
// A table of SLOTS one-shot pulse slots. A start item (action = 1) yields one
// drive result at once: the pin is driven to the inverse of end_level, and
// slot_taken tells whether a free slot (lowest index first) took the pin with
// a deadline of now_ms + duration_ms, wrapping at 2^32. A tick item
// (action = 0) frees the busy slots whose deadline is at or below now_ms in
// plain unsigned terms and yields one toggle result per freed slot, in slot
// order, at most four per tick; further due slots wait for a later tick. The
// last result of an item carries last = 1; a tick with nothing due yields no
// result. The result of a start item sits in the output register the cycle
// after the transfer. A tick first latches the time, then compares all
// deadlines in parallel, then loads its toggles one after another, holding
// while the output register is full, or finds that nothing is due. The
// single output register and the shared table mean that the next item is
// taken once the controller is back in idle and the output register is free
// or being drained. In the table, reset clears only the busy flags; slot
// contents are written before they are read.

`include "timed_pin_pulse_table_macros.svh"

module timed_pin_pulse_table #(
   parameter int SLOTS       = 4,
   parameter int PIN_ID_BITS = 6
) (
   input logic        clock,
   input logic        reset,
   tppt_req_if.sink   req_chan,
   tppt_rsp_if.source rsp_chan
);
   import tppt_pkg::*;

   tppt_cmd_type  cmd;
   tppt_stat_type stat;

   // Terms for the checks at the end.
   logic rsp_room;
   logic start_xfer;
   logic drive_out;
   logic toggle_mid;

   // Sequence items: accept, scan deadlines, emit toggles one per cycle while the output is free.
   tppt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Hold the slot table and the result register.
   tppt_datapath #(
      .SLOTS       (SLOTS),
      .PIN_ID_BITS (PIN_ID_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_now_ms      (req_chan.now_ms),
      .req_pin_id      (req_chan.pin_id),
      .req_duration_ms (req_chan.duration_ms),
      .req_end_level   (req_chan.end_level),
      .rsp_out_pin     (rsp_chan.out_pin),
      .rsp_command     (rsp_chan.command),
      .rsp_drive_level (rsp_chan.drive_level),
      .rsp_slot_taken  (rsp_chan.slot_taken),
      .rsp_last        (rsp_chan.last)
   );

   assign rsp_room   = !rsp_chan.valid || rsp_chan.ready;
   assign start_xfer = req_chan.valid && req_chan.ready && (req_chan.action == ACTION_START);
   assign drive_out  = rsp_chan.valid && rsp_chan.last && (rsp_chan.command == CMD_DRIVE);
   assign toggle_mid = rsp_chan.valid && (rsp_chan.command == CMD_TOGGLE) && !rsp_chan.last;

   // Accept a request only when the output register can take its result.
   `TPPT_ASSERT_SAME(a_ready_needs_room, req_chan.ready, rsp_room, "ready with output blocked")

   // A start transfer loads a final drive result.
   `TPPT_ASSERT_NEXT(a_start_gives_drive, start_xfer, drive_out, "start without drive result")

   // Block new requests while a tick still has toggles to send.
   `TPPT_ASSERT_SAME(a_toggle_run_blocks, toggle_mid, !req_chan.ready, "ready during toggle run")

endmodule
